// ----- rtl/core/stsm_pkg.sv -----
// Shared constants, codes and types of the sensor timestamp skew monitor.
`timescale 1ns / 1ps
package stsm_pkg;
	localparam int NUM_SENSORS_DEF = 16;
	localparam int MASK_SLOTS      = 16;
	localparam int SKEW_W          = 48;
	localparam int TS_W            = 63;
	localparam int IDX_W           = 4;
	localparam int CFG_W           = 48;
	localparam int CFGI_W          = 2;

	// Register indexes of the configuration port
	localparam logic [CFGI_W-1:0] REG_MASK   = 2'd0;
	localparam logic [CFGI_W-1:0] REG_TARGET = 2'd1;
	localparam logic [CFGI_W-1:0] REG_P95    = 2'd2;

	localparam logic [SKEW_W-1:0] TARGET_RST = 48'd1000000;
	localparam logic [SKEW_W-1:0] P95_RST    = 48'd5000000;

	// Status codes
	localparam logic [1:0] ST_UNDER_REG = 2'd0;
	localparam logic [1:0] ST_UNDER_TS  = 2'd1;
	localparam logic [1:0] ST_STATS     = 2'd2;

	// floor(19*p/20) == (p*62263) >> 16 for p below 862
	localparam int RANK_MUL_W = 17;
	localparam logic [RANK_MUL_W-1:0] RANK_MUL = 17'd62263;
	localparam int RANK_SHIFT = 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROT,
		S_DRAIN,
		S_EVAL,
		S_DIV,
		S_SRCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic acc;
		logic drain;
	} cell_ctrl_t;
endpackage

// ----- rtl/core/stsm_cell.sv -----
// One sensor slot: stored timestamp, rotating ring stage, pair compare and drainable totals.
`timescale 1ns / 1ps
module stsm_cell import stsm_pkg::*; #(
	parameter int NUM_SENSORS = NUM_SENSORS_DEF,
	parameter int SLOT = 0,
	localparam int IW = $clog2(NUM_SENSORS),
	localparam int CW = $clog2(NUM_SENSORS),
	localparam int SUMW = SKEW_W + CW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [SKEW_W-1:0] test,
	input  logic              wr_en,
	input  logic [TS_W-1:0]   wr_data,
	input  logic              clr,
	input  logic              reg_bit,
	input  logic [TS_W-1:0]   rot_ts_in,
	input  logic [IW-1:0]     rot_src_in,
	input  logic              rot_val_in,
	output logic [TS_W-1:0]   rot_ts_out,
	output logic [IW-1:0]     rot_src_out,
	output logic              rot_val_out,
	input  logic [SUMW-1:0]   sum_in,
	input  logic [SKEW_W-1:0] max_in,
	input  logic [CW-1:0]     cnt_in,
	input  logic              reg_in,
	input  logic              val_in,
	output logic [SUMW-1:0]   sum_out,
	output logic [SKEW_W-1:0] max_out,
	output logic [CW-1:0]     cnt_out,
	output logic              reg_out,
	output logic              val_out
);
	logic [TS_W-1:0]   ts_q;
	logic [TS_W-1:0]   rot_ts_q;
	logic [IW-1:0]     rot_src_q;
	logic              rot_val_q;
	logic              own_val;
	logic [TS_W-1:0]   diff;
	logic [SKEW_W-1:0] d_sat;
	logic              pv;
	logic [SKEW_W-1:0] d_s1;
	logic              pv_s1;
	logic              le_s1;
	logic [SUMW-1:0]   sum_q;
	logic [SKEW_W-1:0] max_q;
	logic [CW-1:0]     cnt_q;
	logic              a_reg_q;
	logic              a_val_q;

	assign own_val = reg_bit && (ts_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= '0;
		end else if (clr) begin
			ts_q <= '0;
		end else if (wr_en && reg_bit) begin
			ts_q <= wr_data;
		end
	end

	// Ring: load own value, then advance one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_ts_q  <= '0;
			rot_src_q <= '0;
			rot_val_q <= 1'b0;
		end else if (ctrl.load) begin
			rot_ts_q  <= ts_q;
			rot_src_q <= IW'(SLOT);
			rot_val_q <= own_val;
		end else if (ctrl.shift) begin
			rot_ts_q  <= rot_ts_in;
			rot_src_q <= rot_src_in;
			rot_val_q <= rot_val_in;
		end
	end

	assign rot_ts_out  = rot_ts_q;
	assign rot_src_out = rot_src_q;
	assign rot_val_out = rot_val_q;

	always_comb begin
		diff  = (ts_q >= rot_ts_q) ? (ts_q - rot_ts_q) : (rot_ts_q - ts_q);
		d_sat = (|diff[TS_W-1:SKEW_W]) ? '1 : diff[SKEW_W-1:0];
		// count each pair once, at the cell with the higher slot number
		pv    = own_val && rot_val_q && (rot_src_q < IW'(SLOT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			le_s1 <= 1'b0;
		end else begin
			pv_s1 <= pv;
			le_s1 <= pv && (d_sat <= test);
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= d_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			max_q   <= '0;
			cnt_q   <= '0;
			a_reg_q <= 1'b0;
			a_val_q <= 1'b0;
		end else if (ctrl.load) begin
			sum_q   <= '0;
			max_q   <= '0;
			cnt_q   <= '0;
			a_reg_q <= reg_bit;
			a_val_q <= own_val;
		end else if (ctrl.drain) begin
			sum_q   <= sum_in;
			max_q   <= max_in;
			cnt_q   <= cnt_in;
			a_reg_q <= reg_in;
			a_val_q <= val_in;
		end else if (ctrl.acc && pv_s1) begin
			sum_q <= sum_q + SUMW'(d_s1);
			if (d_s1 > max_q) begin
				max_q <= d_s1;
			end
			cnt_q <= cnt_q + CW'(le_s1);
		end
	end

	assign sum_out = sum_q;
	assign max_out = max_q;
	assign cnt_out = cnt_q;
	assign reg_out = a_reg_q;
	assign val_out = a_val_q;
endmodule

// ----- rtl/core/stsm_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module stsm_div import stsm_pkg::*; #(
	parameter int NW = 56,
	parameter int DW = 8,
	localparam int KW = $clog2(NW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);
	logic          busy_q;
	logic          done_q;
	logic [KW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quot_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   rem_n;

	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		ge    = trial >= {1'b0, den_q};
		rem_n = ge ? (trial - {1'b0, den_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			rem_q  <= rem_n[DW-1:0];
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

// ----- rtl/core/sensor_timestamp_skew_monitor.sv -----
// Latency: one pass around the cell ring, a divide for the mean and 48 rank-search passes;
// cases with under two sensors skip the divide and the search.
// Throughput: one transaction at a time; a new one is taken only once the last is done.
// A finished result waits in the output register while the next transaction is taken.
// Reset clears all timestamps and the mask and loads the default skew limits.
`timescale 1ns / 1ps
module sensor_timestamp_skew_monitor import stsm_pkg::*; #(
	parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [IDX_W-1:0]  sensor_index,
	input  logic [TS_W-1:0]   timestamp_ns,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status_case,
	output logic              synchronized,
	output logic [SKEW_W-1:0] mean_skew_ns,
	output logic [SKEW_W-1:0] p95_skew_ns,
	output logic [SKEW_W-1:0] max_skew_ns
);
	localparam int IW   = $clog2(NUM_SENSORS);
	localparam int CW   = $clog2(NUM_SENSORS);
	localparam int SUMW = SKEW_W + CW;
	localparam int PW   = $clog2(NUM_SENSORS * (NUM_SENSORS - 1) / 2 + 1);
	localparam int SW   = SKEW_W + PW;
	localparam int RW   = $clog2(NUM_SENSORS + 1);
	localparam int KW   = $clog2(NUM_SENSORS + 2);
	localparam int MW   = PW + RANK_MUL_W;

	state_t state_q, state_n;
	cell_ctrl_t ctrl;

	logic [MASK_SLOTS-1:0] mask_q;
	logic [SKEW_W-1:0]     target_q;
	logic [SKEW_W-1:0]     limit_q;

	logic [KW-1:0]     cnt_q;
	logic              srch_q;
	logic [SKEW_W-1:0] test_q;
	logic [SKEW_W-1:0] ans_q;
	logic [SKEW_W-1:0] bit_q;
	logic [PW-1:0]     rank_q;
	logic [SW-1:0]     tot_sum_q;
	logic [SKEW_W-1:0] tot_max_q;
	logic [PW-1:0]     tot_cnt_q;
	logic [RW-1:0]     nreg_q;
	logic [RW-1:0]     nts_q;
	logic [1:0]        res_case_q;
	logic [SKEW_W-1:0] res_mean_q;
	logic              res_exact_q;
	logic [SKEW_W-1:0] res_p95_q;
	logic [SKEW_W-1:0] res_max_q;
	logic              out_valid_q;
	logic [1:0]        out_case_q;
	logic              out_sync_q;
	logic [SKEW_W-1:0] out_mean_q;
	logic [SKEW_W-1:0] out_p95_q;
	logic [SKEW_W-1:0] out_max_q;

	logic              accept;
	logic              out_free;
	logic              div_start;
	logic              div_done;
	logic [SW-1:0]     div_quot;
	logic [PW-1:0]     div_rem;
	logic [MW-1:0]     rank_prod;
	logic [SKEW_W-1:0] ans_n;
	logic [SKEW_W-1:0] bit_n;

	logic [TS_W-1:0]   rot_ts  [NUM_SENSORS];
	logic [IW-1:0]     rot_src [NUM_SENSORS];
	logic              rot_val [NUM_SENSORS];
	logic [SUMW-1:0]   c_sum   [NUM_SENSORS];
	logic [SKEW_W-1:0] c_max   [NUM_SENSORS];
	logic [CW-1:0]     c_cnt   [NUM_SENSORS];
	logic              c_reg   [NUM_SENSORS];
	logic              c_val   [NUM_SENSORS];

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			target_q <= TARGET_RST;
			limit_q  <= P95_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASK:   mask_q   <= cfg_wdata[MASK_SLOTS-1:0];
				REG_TARGET: target_q <= cfg_wdata[SKEW_W-1:0];
				REG_P95:    limit_q  <= cfg_wdata[SKEW_W-1:0];
				default:    ;
			endcase
		end
	end

	genvar j;
	generate
		for (j = 0; j < NUM_SENSORS; j++) begin : g_cell
			logic reg_bit;
			logic clr;
			logic wr_en;
			logic [SUMW-1:0]   d_sum;
			logic [SKEW_W-1:0] d_max;
			logic [CW-1:0]     d_cnt;
			logic              d_reg;
			logic              d_val;

			if (j < MASK_SLOTS) begin : g_reg
				assign reg_bit = mask_q[j];
				// a fresh registration starts with no timestamp
				assign clr = cfg_we && (cfg_index == REG_MASK) && cfg_wdata[j] && !mask_q[j];
				assign wr_en = accept && (sensor_index == IDX_W'(j));
			end else begin : g_noreg
				assign reg_bit = 1'b0;
				assign clr     = 1'b0;
				assign wr_en   = 1'b0;
			end

			if (j == NUM_SENSORS - 1) begin : g_tail
				assign d_sum = '0;
				assign d_max = '0;
				assign d_cnt = '0;
				assign d_reg = 1'b0;
				assign d_val = 1'b0;
			end else begin : g_mid
				assign d_sum = c_sum[j+1];
				assign d_max = c_max[j+1];
				assign d_cnt = c_cnt[j+1];
				assign d_reg = c_reg[j+1];
				assign d_val = c_val[j+1];
			end

			stsm_cell #(
				.NUM_SENSORS(NUM_SENSORS),
				.SLOT(j)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.test       (test_q),
				.wr_en      (wr_en),
				.wr_data    (timestamp_ns),
				.clr        (clr),
				.reg_bit    (reg_bit),
				.rot_ts_in  (rot_ts[(j + NUM_SENSORS - 1) % NUM_SENSORS]),
				.rot_src_in (rot_src[(j + NUM_SENSORS - 1) % NUM_SENSORS]),
				.rot_val_in (rot_val[(j + NUM_SENSORS - 1) % NUM_SENSORS]),
				.rot_ts_out (rot_ts[j]),
				.rot_src_out(rot_src[j]),
				.rot_val_out(rot_val[j]),
				.sum_in     (d_sum),
				.max_in     (d_max),
				.cnt_in     (d_cnt),
				.reg_in     (d_reg),
				.val_in     (d_val),
				.sum_out    (c_sum[j]),
				.max_out    (c_max[j]),
				.cnt_out    (c_cnt[j]),
				.reg_out    (c_reg[j]),
				.val_out    (c_val[j])
			);
		end
	endgenerate

	stsm_div #(
		.NW(SW),
		.DW(PW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (tot_sum_q),
		.den   (tot_cnt_q),
		.done  (div_done),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	always_comb begin
		rank_prod = MW'(tot_cnt_q) * MW'(RANK_MUL);
		ans_n     = ans_q | ((tot_cnt_q <= rank_q) ? bit_q : '0);
		bit_n     = bit_q >> 1;
	end

	always_comb begin
		state_n    = state_q;
		ctrl       = '0;
		in_ready   = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_n = S_ROT;
				end
			end
			S_ROT: begin
				ctrl.load  = (cnt_q == '0);
				ctrl.shift = (cnt_q != '0) && (cnt_q <= KW'(NUM_SENSORS - 1));
				ctrl.acc   = (cnt_q >= KW'(2));
				if (cnt_q == KW'(NUM_SENSORS + 1)) begin
					state_n = S_DRAIN;
				end
			end
			S_DRAIN: begin
				ctrl.drain = 1'b1;
				if (cnt_q == KW'(NUM_SENSORS - 1)) begin
					state_n = srch_q ? S_SRCH : S_EVAL;
				end
			end
			S_EVAL: begin
				if (nreg_q < RW'(2) || nts_q < RW'(2)) begin
					state_n = S_DONE;
				end else begin
					div_start = 1'b1;
					state_n   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_n = S_ROT;
				end
			end
			S_SRCH: begin
				state_n = bit_q[0] ? S_DONE : S_ROT;
			end
			S_DONE: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			srch_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q != state_n) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				srch_q <= 1'b0;
			end else if (state_q == S_DIV && div_done) begin
				srch_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				test_q <= '1;
			end
			S_ROT: begin
				if (cnt_q == '0) begin
					tot_sum_q <= '0;
					tot_max_q <= '0;
					tot_cnt_q <= '0;
					nreg_q    <= '0;
					nts_q     <= '0;
				end
			end
			S_DRAIN: begin
				// add the totals coming out of cell 0
				tot_sum_q <= tot_sum_q + SW'(c_sum[0]);
				if (c_max[0] > tot_max_q) begin
					tot_max_q <= c_max[0];
				end
				tot_cnt_q <= tot_cnt_q + PW'(c_cnt[0]);
				nreg_q    <= nreg_q + RW'(c_reg[0]);
				nts_q     <= nts_q + RW'(c_val[0]);
			end
			S_EVAL: begin
				if (nreg_q < RW'(2)) begin
					res_case_q <= ST_UNDER_REG;
				end else if (nts_q < RW'(2)) begin
					res_case_q <= ST_UNDER_TS;
				end else begin
					res_case_q <= ST_STATS;
				end
				res_max_q <= tot_max_q;
				rank_q    <= rank_prod[RANK_SHIFT +: PW];
			end
			S_DIV: begin
				if (div_done) begin
					res_mean_q  <= div_quot[SKEW_W-1:0];
					res_exact_q <= (div_rem == '0);
					ans_q       <= '0;
					bit_q       <= {1'b1, {(SKEW_W-1){1'b0}}};
					test_q      <= {1'b0, {(SKEW_W-1){1'b1}}};
				end
			end
			S_SRCH: begin
				// keep bit clear when enough pairs lie at or below the trial value
				ans_q     <= ans_n;
				bit_q     <= bit_n;
				test_q    <= ans_n | (bit_n - 1'b1);
				res_p95_q <= ans_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_case_q <= res_case_q;
			case (res_case_q)
				ST_UNDER_REG: out_sync_q <= 1'b1;
				// sum <= target*count: quotient below target, or equal with no remainder
				ST_STATS:     out_sync_q <= ((res_mean_q < target_q) ||
						((res_mean_q == target_q) && res_exact_q)) &&
						(res_p95_q <= limit_q);
				default:      out_sync_q <= 1'b0;
			endcase
			if (res_case_q == ST_STATS) begin
				out_mean_q <= res_mean_q;
				out_p95_q  <= res_p95_q;
				out_max_q  <= res_max_q;
			end else begin
				out_mean_q <= '0;
				out_p95_q  <= '0;
				out_max_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status_case  = out_case_q;
	assign synchronized = out_sync_q;
	assign mean_skew_ns = out_mean_q;
	assign p95_skew_ns  = out_p95_q;
	assign max_skew_ns  = out_max_q;

	a_case0_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_case == ST_UNDER_REG |-> synchronized)
		else $error("status without registered pair not reported synchronized");

	a_no_stats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_case != ST_STATS |->
		mean_skew_ns == '0 && p95_skew_ns == '0 && max_skew_ns == '0)
		else $error("statistics reported without computed pairs");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_case == ST_STATS |->
		p95_skew_ns <= max_skew_ns && mean_skew_ns <= max_skew_ns)
		else $error("p95 or mean above maximum skew");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while one is in work");
endmodule

// ----- dv/sensor_timestamp_skew_monitor_tb.sv -----
// Self-checking testbench of the sensor timestamp skew monitor.
`timescale 1ns / 1ps
module sensor_timestamp_skew_monitor_tb;
	import stsm_pkg::*;

	localparam logic [CFGI_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [SKEW_W-1:0] SKEW_MAX   = {SKEW_W{1'b1}};
	localparam logic [TS_W-1:0]   TS_MAX     = {TS_W{1'b1}};
	localparam int NSLOT     = NUM_SENSORS_DEF;
	localparam int NPAIR_MAX = NSLOT * (NSLOT - 1) / 2;
	localparam int HOLD_CYCLES = 6000;

	typedef struct packed {
		logic [1:0]        status;
		logic              sync;
		logic [SKEW_W-1:0] mean;
		logic [SKEW_W-1:0] p95;
		logic [SKEW_W-1:0] peak;
	} skew_status_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [IDX_W-1:0]  sensor_index = '0;
	logic [TS_W-1:0]   timestamp_ns = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        status_case;
	logic              synchronized;
	logic [SKEW_W-1:0] mean_skew_ns;
	logic [SKEW_W-1:0] p95_skew_ns;
	logic [SKEW_W-1:0] max_skew_ns;

	sensor_timestamp_skew_monitor u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.sensor_index(sensor_index), .timestamp_ns(timestamp_ns),
		.out_valid(out_valid), .out_ready(out_ready),
		.status_case(status_case), .synchronized(synchronized),
		.mean_skew_ns(mean_skew_ns), .p95_skew_ns(p95_skew_ns),
		.max_skew_ns(max_skew_ns)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow state of the monitor
	logic [TS_W-1:0]   slot_ts [NSLOT];
	logic [15:0]       slot_mask;
	logic [SKEW_W-1:0] mean_limit;
	logic [SKEW_W-1:0] p95_limit;

	skew_status_t pending_status[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	logic [TS_W-1:0] ts_base;

	function automatic skew_status_t compute_skew_status(logic [IDX_W-1:0] idx,
			logic [TS_W-1:0] ts);
		logic [TS_W-1:0]   vals [NSLOT];
		logic [SKEW_W-1:0] skews [NPAIR_MAX];
		logic [SKEW_W-1:0] tmp;
		logic [63:0]       d;
		logic [63:0]       sum;
		skew_status_t      r;
		int nreg, nts, np, rank;
		nreg = 0; nts = 0; np = 0; sum = 0;
		r = '0;
		if (slot_mask[idx])
			slot_ts[idx] = ts;
		for (int i = 0; i < NSLOT; i++) begin
			if (slot_mask[i]) begin
				nreg++;
				if (slot_ts[i] != 0) begin
					vals[nts] = slot_ts[i];
					nts++;
				end
			end
		end
		if (nreg < 2) begin
			r.status = ST_UNDER_REG;
			r.sync = 1'b1;
			return r;
		end
		if (nts < 2) begin
			r.status = ST_UNDER_TS;
			return r;
		end
		for (int i = 0; i < nts; i++) begin
			for (int j = i + 1; j < nts; j++) begin
				d = (vals[i] >= vals[j]) ? 64'(vals[i] - vals[j]) : 64'(vals[j] - vals[i]);
				if (d > 64'(SKEW_MAX))
					d = 64'(SKEW_MAX);
				skews[np] = d[SKEW_W-1:0];
				sum += d;
				np++;
			end
		end
		for (int i = 1; i < np; i++) begin
			for (int k = i; k > 0 && skews[k-1] > skews[k]; k--) begin
				tmp = skews[k]; skews[k] = skews[k-1]; skews[k-1] = tmp;
			end
		end
		rank = np * 19 / 20;
		if (rank >= np)
			rank = np - 1;
		r.status = ST_STATS;
		r.p95 = skews[rank];
		r.peak = skews[np-1];
		r.mean = 48'(sum / 64'(np));
		r.sync = (sum <= 64'(mean_limit) * 64'(np)) && (skews[rank] <= p95_limit);
		return r;
	endfunction

	task automatic wait_idle();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	// Write one register once every transaction in flight has come out
	task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MASK: begin
				for (int s = 0; s < NSLOT; s++)
					if (data[s] && !slot_mask[s])
						slot_ts[s] = '0;
				slot_mask = data[15:0];
			end
			REG_TARGET: mean_limit = data[SKEW_W-1:0];
			REG_P95:    p95_limit = data[SKEW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_timestamp(logic [IDX_W-1:0] idx, logic [TS_W-1:0] ts);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		sensor_index <= idx;
		timestamp_ns <= ts;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_status.insert(pending_status.size(), compute_skew_status(idx, ts));
	endtask

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		skew_status_t exp_s;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d", status_case);
			end else begin
				exp_s = pending_status.pop_front();
				if (status_case !== exp_s.status || synchronized !== exp_s.sync ||
						mean_skew_ns !== exp_s.mean || p95_skew_ns !== exp_s.p95 ||
						max_skew_ns !== exp_s.peak) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %0d %0d %0d %0d %0d / got %0d %0d %0d %0d %0d",
							exp_s.status, exp_s.sync, exp_s.mean, exp_s.p95, exp_s.peak,
							status_case, synchronized, mean_skew_ns, p95_skew_ns,
							max_skew_ns);
				end
			end
		end
	end

	task automatic test_under_registered();
		send_timestamp(4'd0, 63'd100);
		write_reg(REG_MASK, 48'h0001);
		send_timestamp(4'd0, 63'd100);
		send_timestamp(4'd5, 63'd7);
		wait_idle();
	endtask

	task automatic test_under_timestamped();
		write_reg(REG_MASK, 48'h8001);
		send_timestamp(4'd0, 63'd0);
		send_timestamp(4'd15, 63'd0);
		send_timestamp(4'd0, 63'd1234);
		wait_idle();
	endtask

	task automatic test_statistics();
		send_timestamp(4'd15, 63'd1000);
		send_timestamp(4'd0, TS_MAX);
		send_timestamp(4'd15, 63'd1);
		send_timestamp(4'd7, 63'd55);
		wait_idle();
		write_reg(REG_MASK, 48'hFFFF);
		for (int s = 0; s < NSLOT; s++)
			send_timestamp(4'(s), 63'(1000 * s + 1));
		wait_idle();
	endtask

	task automatic test_registration_changes();
		write_reg(REG_MASK, 48'h00F0);
		send_timestamp(4'd4, 63'd9);
		write_reg(REG_MASK, 48'h00FF);
		send_timestamp(4'd0, 63'd3);
		write_reg(REG_UNUSED, {CFG_W{1'b1}});
		write_reg(REG_TARGET, '0);
		write_reg(REG_P95, '0);
		send_timestamp(4'd1, 63'd3);
		write_reg(REG_TARGET, {CFG_W{1'b1}});
		write_reg(REG_P95, {CFG_W{1'b1}});
		send_timestamp(4'd2, TS_MAX);
		wait_idle();
	endtask

	task automatic random_phase(int n_items);
		logic [IDX_W-1:0] idx;
		logic [TS_W-1:0]  ts;
		for (int i = 0; i < n_items; i++) begin
			idx = 4'($urandom_range(15));
			case ($urandom_range(9))
				0:       ts = 63'({$urandom, $urandom});
				1:       ts = '0;
				default: ts = ts_base + 63'($urandom_range(20000000));
			endcase
			send_timestamp(idx, ts);
		end
		wait_idle();
	endtask

	task automatic random_config();
		write_reg(REG_MASK, 48'($urandom_range(65535) | 16'h0101));
		write_reg(REG_TARGET, 48'($urandom_range(12000000)));
		write_reg(REG_P95, 48'($urandom_range(25000000)));
		ts_base = 63'({$urandom, $urandom});
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++)
			send_timestamp(4'($urandom_range(15)), ts_base + 63'($urandom_range(1000)));
		wait_idle();
	endtask

	initial begin
		for (int s = 0; s < NSLOT; s++)
			slot_ts[s] = '0;
		slot_mask = '0;
		mean_limit = TARGET_RST;
		p95_limit = P95_RST;
		ts_base = 63'd1000000000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_under_registered();
		test_under_timestamped();
		test_statistics();
		test_registration_changes();
		send_idle_pct = 33;
		recv_idle_pct = 69;
		random_config();
		random_phase(20);
		send_idle_pct = 69;
		recv_idle_pct = 33;
		random_config();
		random_phase(20);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_config();
		test_backpressure();
		random_phase(18);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#30ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
